// File: sv/single_pair_json_parser_defines.svh
// Assertion helpers used by the top-level parser file.
`ifndef SINGLE_PAIR_JSON_PARSER_DEFINES_SVH
`define SINGLE_PAIR_JSON_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define SPJP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SPJP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/spjp_pkg.sv
package spjp_pkg;

	localparam int KEY_MAX      = 16;
	localparam int VALUE_MAX    = 48;
	localparam int RESULT_LIMIT = 64;

	localparam int CHAR_W    = 7;
	localparam int KEY_LEN_W = $clog2(KEY_MAX + 1);
	localparam int VAL_LEN_W = $clog2(VALUE_MAX + 1);
	localparam int KEY_IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int VAL_IDX_W = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
	localparam int SUM_W     = $clog2(KEY_MAX + VALUE_MAX + 1);
	localparam int POS_W     = (SUM_W > $clog2(RESULT_LIMIT + 1)) ? SUM_W
	                                                              : $clog2(RESULT_LIMIT + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SYNTAX     = 3'd1,
		ST_KEY_LONG   = 3'd2,
		ST_VALUE_LONG = 3'd3,
		ST_UNFINISHED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PART_KEY    = 2'd0,
		PART_VALUE  = 2'd1,
		PART_STATUS = 2'd2
	} part_t;

	typedef enum logic [1:0] {
		CMD_KEY    = 2'd0,
		CMD_VALUE  = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_op_t;

	// One command from the parser to the readout side. For a key or value write,
	// key_len or val_len holds the write index; for a finish, the final lengths.
	typedef struct packed {
		cmd_op_t               op;
		logic [CHAR_W-1:0]     ch;
		logic [KEY_LEN_W-1:0]  key_len;
		logic [VAL_LEN_W-1:0]  val_len;
		logic                  emit;
		status_t               status;
	} cmd_t;

	// Queue status seen by the readout side.
	typedef struct packed {
		logic empty;
		cmd_t head;
	} queue_view_t;

endpackage

// File: sv/spjp_if.sv
interface spjp_in_if;
	import spjp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_message;

	modport source (output valid, output byte_in, output end_of_message, input ready);
	modport sink (input valid, input byte_in, input end_of_message, output ready);
endinterface

interface spjp_out_if;
	import spjp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic [1:0] part;
	logic [2:0] status;
	logic       last_of_run;

	modport source (output valid, output char_out, output part, output status,
		output last_of_run, input ready);
	modport sink (input valid, input char_out, input part, input status,
		input last_of_run, output ready);
endinterface

// File: sv/spjp_front.sv
module spjp_front (
	input  logic          clk,
	input  logic          arst_n,
	spjp_in_if.sink       byte_ch,
	output spjp_pkg::cmd_t cmd,
	output logic          cmd_push,
	input  logic          cmd_full
);
	import spjp_pkg::*;

	typedef enum logic [3:0] {
		PH_OPEN,
		PH_KEY_QUOTE,
		PH_KEY,
		PH_COLON,
		PH_VALUE_QUOTE,
		PH_VALUE,
		PH_BRACE,
		PH_DONE,
		PH_FAILED
	} phase_t;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_D0     = 8'h30;
	localparam logic [7:0] CH_D9     = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= CH_D0 && c <= CH_D9) || (c >= CH_UA && c <= CH_UZ) ||
		       (c >= CH_LA && c <= CH_LZ);
	endfunction

	phase_t                phase_q, phase_d;
	status_t               err_q, err_d;
	logic [KEY_LEN_W-1:0]  klen_q, klen_d;
	logic [VAL_LEN_W-1:0]  vlen_q, vlen_d;
	logic                  store_key, store_val;
	logic                  accept;
	logic [7:0]            c;

	assign c             = byte_ch.byte_in;
	assign byte_ch.ready = !cmd_full;
	assign accept        = byte_ch.valid && byte_ch.ready;

	always_comb begin
		phase_d   = phase_q;
		err_d     = err_q;
		klen_d    = klen_q;
		vlen_d    = vlen_q;
		store_key = 1'b0;
		store_val = 1'b0;
		case (phase_q)
			PH_OPEN: begin
				if (c == CH_LBRACE) begin
					phase_d = PH_KEY_QUOTE;
				end else begin
					phase_d = PH_FAILED;
					err_d   = ST_SYNTAX;
				end
			end
			PH_KEY_QUOTE: begin
				if (c == CH_QUOTE) begin
					phase_d = PH_KEY;
				end else begin
					phase_d = PH_FAILED;
					err_d   = ST_SYNTAX;
				end
			end
			PH_COLON: begin
				if (c == CH_COLON) begin
					phase_d = PH_VALUE_QUOTE;
				end else begin
					phase_d = PH_FAILED;
					err_d   = ST_SYNTAX;
				end
			end
			PH_VALUE_QUOTE: begin
				if (c == CH_QUOTE) begin
					phase_d = PH_VALUE;
				end else begin
					phase_d = PH_FAILED;
					err_d   = ST_SYNTAX;
				end
			end
			PH_BRACE: begin
				if (c == CH_RBRACE) begin
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_FAILED;
					err_d   = ST_SYNTAX;
				end
			end
			PH_KEY: begin
				if (c == CH_QUOTE) begin
					phase_d = PH_COLON;
				end else if (is_alnum(c)) begin
					if (klen_q >= KEY_LEN_W'(KEY_MAX)) begin
						phase_d = PH_FAILED;
						err_d   = ST_KEY_LONG;
					end else begin
						store_key = 1'b1;
						klen_d    = klen_q + 1'b1;
					end
				end else begin
					phase_d = PH_FAILED;
					err_d   = ST_SYNTAX;
				end
			end
			PH_VALUE: begin
				if (c == CH_QUOTE) begin
					phase_d = PH_BRACE;
				end else if (is_alnum(c) || c == CH_DOT) begin
					if (vlen_q >= VAL_LEN_W'(VALUE_MAX)) begin
						phase_d = PH_FAILED;
						err_d   = ST_VALUE_LONG;
					end else begin
						store_val = 1'b1;
						vlen_d    = vlen_q + 1'b1;
					end
				end else begin
					phase_d = PH_FAILED;
					err_d   = ST_SYNTAX;
				end
			end
			default: begin
			end
		endcase
	end

	// A final byte only ever yields the finish command: a byte that stores a
	// character cannot also complete the message.
	always_comb begin
		cmd.ch      = c[CHAR_W-1:0];
		cmd.emit    = 1'b0;
		cmd.status  = ST_OK;
		cmd.key_len = klen_q;
		cmd.val_len = vlen_q;
		if (byte_ch.end_of_message) begin
			cmd.op      = CMD_FINISH;
			cmd.key_len = klen_d;
			cmd.val_len = vlen_d;
			cmd.emit    = (phase_d == PH_DONE) && (klen_d != '0 || vlen_d != '0);
			if (phase_d == PH_FAILED) begin
				cmd.status = err_d;
			end else if (!cmd.emit) begin
				cmd.status = ST_UNFINISHED;
			end
		end else if (store_key) begin
			cmd.op = CMD_KEY;
		end else begin
			cmd.op = CMD_VALUE;
		end
	end

	assign cmd_push = accept && (byte_ch.end_of_message || store_key || store_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			err_q   <= ST_OK;
			klen_q  <= '0;
			vlen_q  <= '0;
		end else if (accept) begin
			if (byte_ch.end_of_message) begin
				phase_q <= PH_OPEN;
				err_q   <= ST_OK;
				klen_q  <= '0;
				vlen_q  <= '0;
			end else begin
				phase_q <= phase_d;
				err_q   <= err_d;
				klen_q  <= klen_d;
				vlen_q  <= vlen_d;
			end
		end
	end

endmodule

// File: sv/spjp_cmd_queue.sv
module spjp_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spjp_pkg::cmd_t        push_data,
	input  logic                  push,
	output logic                  full,
	output spjp_pkg::queue_view_t view,
	input  logic                  pop
);
	import spjp_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign view.empty = (count_q == '0);
	assign view.head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/spjp_back.sv
module spjp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spjp_pkg::queue_view_t view,
	output logic                  pop,
	spjp_out_if.source            result_ch
);
	import spjp_pkg::*;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} bk_state_t;

	logic [CHAR_W-1:0] key_mem [KEY_MAX];
	logic [CHAR_W-1:0] val_mem [VALUE_MAX];
	logic [CHAR_W-1:0] key_rd_q, val_rd_q;

	bk_state_t            state_q;
	logic [POS_W-1:0]     pos_q, last_pos_q, next_pos, val_off;
	logic [KEY_LEN_W-1:0] klen_q, klen_sel;
	logic                 can_load, advance, next_in_key, cur_in_key, is_finish;
	logic [SUM_W-1:0]     sum;
	logic [POS_W-1:0]     total;
	logic [KEY_IDX_W-1:0] key_addr;
	logic [VAL_IDX_W-1:0] val_addr;

	logic                 out_valid_q, last_q, load_out;
	logic [7:0]           char_q;
	part_t                part_q;
	status_t              status_q;

	assign can_load  = !out_valid_q || result_ch.ready;
	assign is_finish = (view.head.op == CMD_FINISH);
	assign pop       = (state_q == BK_IDLE) && !view.empty && (!is_finish || can_load);
	assign advance   = (state_q == BK_EMIT) && can_load;
	assign load_out  = advance ||
	                   ((state_q == BK_IDLE) && pop && is_finish && !view.head.emit);

	assign sum   = SUM_W'(view.head.key_len) + SUM_W'(view.head.val_len);
	assign total = (sum > SUM_W'(RESULT_LIMIT)) ? POS_W'(RESULT_LIMIT) : POS_W'(sum);

	// In the emit state the read registers hold the entry at pos_q, so the address is
	// looked up one step ahead whenever the output register takes an item.
	always_comb begin
		if (state_q == BK_IDLE) begin
			next_pos = '0;
			klen_sel = view.head.key_len;
		end else begin
			next_pos = advance ? pos_q + 1'b1 : pos_q;
			klen_sel = klen_q;
		end
		next_in_key = next_pos < POS_W'(klen_sel);
		val_off     = next_pos - POS_W'(klen_sel);
		key_addr    = next_in_key ? next_pos[KEY_IDX_W-1:0] : '0;
		val_addr    = (!next_in_key && val_off < POS_W'(VALUE_MAX)) ?
		              val_off[VAL_IDX_W-1:0] : '0;
	end

	assign cur_in_key = pos_q < POS_W'(klen_q);

	always_ff @(posedge clk) begin
		if (pop && view.head.op == CMD_KEY) begin
			key_mem[view.head.key_len[KEY_IDX_W-1:0]] <= view.head.ch;
		end
		key_rd_q <= key_mem[key_addr];
	end

	always_ff @(posedge clk) begin
		if (pop && view.head.op == CMD_VALUE) begin
			val_mem[view.head.val_len[VAL_IDX_W-1:0]] <= view.head.ch;
		end
		val_rd_q <= val_mem[val_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pos_q       <= '0;
			last_pos_q  <= '0;
			klen_q      <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			part_q      <= PART_STATUS;
			status_q    <= ST_OK;
			last_q      <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (pop && is_finish) begin
						if (view.head.emit) begin
							state_q    <= BK_EMIT;
							pos_q      <= '0;
							klen_q     <= view.head.key_len;
							last_pos_q <= total - 1'b1;
						end else begin
							char_q      <= '0;
							part_q      <= PART_STATUS;
							status_q    <= view.head.status;
							last_q      <= 1'b1;
						end
					end
				end
				BK_EMIT: begin
					if (can_load) begin
						char_q      <= {1'b0, (cur_in_key ? key_rd_q : val_rd_q)};
						part_q      <= cur_in_key ? PART_KEY : PART_VALUE;
						status_q    <= ST_OK;
						last_q      <= (pos_q == last_pos_q);
						pos_q       <= pos_q + 1'b1;
						if (pos_q == last_pos_q) begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.char_out    = char_q;
	assign result_ch.part        = part_q;
	assign result_ch.status      = status_q;
	assign result_ch.last_of_run = last_q;

endmodule

// File: sv/single_pair_json_parser.sv
// Channel     Dir  Payload                                   Meaning
// byte_ch     in   byte_in[7:0], end_of_message              one message byte
// result_ch   out  char_out[7:0], part[1:0], status[2:0],    key/value character
//                  last_of_run                               or status item
//
// The parser takes one byte per cycle while its four-entry command queue has room;
// bytes that neither store a character nor end a message use no queue entry.
// A finish command at the head of the queue is popped once the output register can take an item; a pair then
// streams one character per cycle while result_ch is ready, min(K+V, 64) items, and a status item is loaded at the pop.
// Reset is asynchronous and active low; the key and value stores are not cleared.
// A stalled result side holds the readout, and the parser stalls once the queue is full.
`include "single_pair_json_parser_defines.svh"

module single_pair_json_parser (
	input  logic       clk,
	input  logic       arst_n,
	spjp_in_if.sink    byte_ch,
	spjp_out_if.source result_ch
);
	import spjp_pkg::*;

	// Front: the parser walks the fixed message shape one byte at a time and
	// turns each meaningful byte into a command (store a key character, store a
	// value character, or finish the message with its outcome).
	cmd_t        cmd;
	logic        cmd_push;
	logic        cmd_full;
	queue_view_t view;
	logic        cmd_pop;

	spjp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.cmd      (cmd),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full)
	);

	// The queue decouples the two halves, so the next message can be parsed
	// while the previous one is still being read out.
	spjp_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (cmd),
		.push      (cmd_push),
		.full      (cmd_full),
		.view      (view),
		.pop       (cmd_pop)
	);

	// Back: writes characters into the key and value stores, and on a finish
	// command streams the pair or emits a single status item.
	spjp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.view      (view),
		.pop       (cmd_pop),
		.result_ch (result_ch)
	);

	// The parser never pushes into a full queue.
	`SPJP_ASSERT_NOW(a_no_push_full, clk, arst_n, cmd_push, !cmd_full, "push into full queue")

	// A status item is always the only and final item of its message.
	`SPJP_ASSERT_NOW(a_status_last, clk, arst_n,
		result_ch.valid && result_ch.part == PART_STATUS,
		result_ch.last_of_run && result_ch.char_out == 8'h00, "malformed status item")

	// Character items always carry the ok status.
	`SPJP_ASSERT_NOW(a_char_ok, clk, arst_n,
		result_ch.valid && result_ch.part != PART_STATUS,
		result_ch.status == ST_OK, "character item with error status")

	// A finish command leaves the queue only when the output side can take it.
	`SPJP_ASSERT_NEXT(a_finish_out, clk, arst_n,
		cmd_pop && view.head.op == CMD_FINISH && !view.head.emit,
		result_ch.valid && result_ch.part == PART_STATUS, "status item not shown")

endmodule
